[hw/rtl/maxstk_pkg.sv]
// Shared types and codes for the max-tracking stack.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package maxstk_pkg;

  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;
  localparam logic [1:0] REQ_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int unsigned CountW = 7;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] item_value;
    logic signed [31:0] largest_value;
    logic [CountW-1:0]  entry_count;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;   // capture the accepted item
    logic rd_en;  // issue the stack reads
    logic exec;   // finish the item and load the result register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_busy;  // result register holds an item that is not taken this cycle
  } stat_t;

endpackage

[hw/rtl/stack_with_max_and_count_top.sv]
// Bounded LIFO stack of signed 32-bit values that also reports the running
// maximum and the entry count with every request.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one item is a push, a
// pop or a peek; request code three behaves as a peek. Output channel
// (out_valid_o / out_ready_i / out_data_o): exactly one result item per
// request, in request order, with status ok, empty or full.
//
// Each item passes through accept, a registered read of the value store and
// the running-maximum store, then execute with the write-back of a push; a
// new item is accepted only after the previous one has executed. The result
// register parts the channels, so the next item is accepted while a result
// waits; execution holds while the receiver stalls and the result stays
// unchanged until taken.
//
// Reset empties the stack and drops any pending result; the stores need no
// clearing since only entries below the fill level affect a result.
// Depends on maxstk_pkg, maxstk_ctrl, maxstk_dp and maxstk_ram.
`timescale 1ns / 1ps

module stack_with_max_and_count_top #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  maxstk_pkg::req_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output maxstk_pkg::rsp_t   out_data_o
);
  import maxstk_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  maxstk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  maxstk_dp #(.StackDepth(STACK_DEPTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[hw/rtl/maxstk_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module maxstk_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hw/rtl/maxstk_ctrl.sv]
// Sequencer for the max-tracking stack: accept, read, execute.
// Depends on maxstk_pkg.
`timescale 1ns / 1ps

module maxstk_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  maxstk_pkg::stat_t   stat_i,
  output maxstk_pkg::cmd_t    cmd_o
);
  import maxstk_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_EXEC;
      end
      S_EXEC: begin
        // hold until the result register has room
        if (!stat_i.out_busy) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/maxstk_dp.sv]
// Datapath of the max-tracking stack: item register, value and maximum stores,
// fill counter and result register. Depends on maxstk_pkg and maxstk_ram.
`timescale 1ns / 1ps

module maxstk_dp #(
  parameter int unsigned StackDepth = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  maxstk_pkg::req_t   in_data_i,
  input  maxstk_pkg::cmd_t   cmd_i,
  output maxstk_pkg::stat_t  stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output maxstk_pkg::rsp_t   out_data_o
);
  import maxstk_pkg::*;

  localparam int unsigned AddrW = $clog2(StackDepth);
  localparam int unsigned CntW  = $clog2(StackDepth + 1);

  localparam logic [CntW-1:0] CntFull = CntW'(StackDepth);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);
  localparam logic [CntW-1:0] CntTwo  = CntW'(2);

  req_t            req_q;
  logic [CntW-1:0] fill_q, fill_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_q, out_d;

  logic [CntW-1:0]  top_idx, below_idx;
  logic [AddrW-1:0] val_rd_addr, max_rd_addr, wr_addr;
  logic [31:0]      val_rd, max_rd, new_max;
  logic             wr_en, is_push, is_pop, is_full, is_empty;

  assign is_push  = (req_q.req_type == REQ_PUSH);
  assign is_pop   = (req_q.req_type == REQ_POP);
  assign is_full  = (fill_q == CntFull);
  assign is_empty = (fill_q == '0);

  assign top_idx     = fill_q - CntOne;
  assign below_idx   = fill_q - CntTwo;
  assign val_rd_addr = top_idx[AddrW-1:0];
  // a pop reports the maximum of the entry left on top
  assign max_rd_addr = is_pop ? below_idx[AddrW-1:0] : top_idx[AddrW-1:0];
  assign wr_addr     = fill_q[AddrW-1:0];

  assign new_max = (!is_empty && ($signed(max_rd) > req_q.push_value))
                   ? max_rd : req_q.push_value;
  assign wr_en   = cmd_i.exec && is_push && !is_full;

  maxstk_ram #(.Width(32), .Depth(StackDepth)) u_val_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (req_q.push_value),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (val_rd_addr),
    .rd_data_o (val_rd)
  );

  maxstk_ram #(.Width(32), .Depth(StackDepth)) u_max_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (new_max),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (max_rd_addr),
    .rd_data_o (max_rd)
  );

  always_comb begin
    fill_d = fill_q;
    out_d  = out_q;
    out_d.status        = ST_OK;
    out_d.item_value    = '0;
    out_d.largest_value = '0;
    if (is_push) begin
      if (is_full) begin
        out_d.status        = ST_FULL;
        out_d.largest_value = max_rd;
      end else begin
        fill_d              = fill_q + CntOne;
        out_d.item_value    = req_q.push_value;
        out_d.largest_value = new_max;
      end
    end else if (is_empty) begin
      out_d.status = ST_EMPTY;
    end else if (is_pop) begin
      fill_d           = top_idx;
      out_d.item_value = val_rd;
      // popping the last entry leaves nothing to report
      out_d.largest_value = (fill_q == CntOne) ? '0 : max_rd;
    end else begin
      out_d.item_value    = val_rd;
      out_d.largest_value = max_rd;
    end
    out_d.entry_count = CountW'(fill_d);
  end

  assign out_valid_d       = cmd_i.exec ? 1'b1 : (out_valid_q && !out_ready_i);
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.exec) begin
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
    end
    if (cmd_i.exec) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sim/tb.sv]
// Self-checking testbench for stack_with_max_and_count_top.
// Predicts every result of the max-tracking stack and checks it in order.
// Depends on maxstk_pkg and the RTL of the stack.
`timescale 1ns / 1ps

module tb;
  import maxstk_pkg::*;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [1:0]  REQ_SPARE   = 2'd3;  // unused code, acts as a peek

  logic clk;
  logic rst_ni;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;

  // Predictor state: stored values, running maxima and the fill level.
  logic signed [31:0] held_vals [STACK_DEPTH];
  logic signed [31:0] run_max [STACK_DEPTH];
  int unsigned        depth_cnt;

  rsp_t        pending_results [$];
  rsp_t        want;
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  bit          idle_en;
  int unsigned hold_req;
  int unsigned ready_gap;

  stack_with_max_and_count_top #(
    .STACK_DEPTH(STACK_DEPTH)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Work out the result of one request and advance the stack copy.
  function automatic rsp_t predict_stack_op(req_t r);
    rsp_t               rsp;
    logic signed [31:0] v;
    rsp = '0;
    v = r.push_value;
    rsp.status = ST_OK;
    if (r.req_type == REQ_PUSH) begin
      if (depth_cnt >= STACK_DEPTH) begin
        rsp.status = ST_FULL;
      end else begin
        held_vals[depth_cnt] = v;
        if (depth_cnt > 0 && run_max[depth_cnt-1] > v) begin
          run_max[depth_cnt] = run_max[depth_cnt-1];
        end else begin
          run_max[depth_cnt] = v;
        end
        depth_cnt++;
        rsp.item_value = v;
      end
    end else if (depth_cnt == 0) begin
      rsp.status = ST_EMPTY;
    end else begin
      rsp.item_value = held_vals[depth_cnt-1];
      if (r.req_type == REQ_POP) depth_cnt--;
    end
    rsp.largest_value = (depth_cnt == 0) ? 32'sd0 : run_max[depth_cnt-1];
    rsp.entry_count = CountW'(depth_cnt);
    return rsp;
  endfunction

  function automatic req_t mk_req(logic [1:0] op, logic [31:0] v);
    req_t r;
    r.req_type = op;
    r.push_value = v;
    return r;
  endfunction

  // Mix extremes, small values and negatives so that maxima change often.
  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = 32'($urandom_range(0, 20)) - 32'd10;
      3, 4: v[31] = 1'b1;
      default: ;
    endcase
    return v;
  endfunction

  // Offer one item at the falling edge and hold it until accepted.
  task automatic send_item(req_t r);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = r;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_stack_op(r));
    @(negedge clk);
  endtask

  task automatic send_op(logic [1:0] op);
    send_item(mk_req(op, rand_value()));
  endtask

  // Receiver: long hold-offs on request, short random stalls while idle_en is set.
  initial begin
    out_ready = 1'b0;
    ready_gap = 0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        out_ready = 1'b0;
        hold_req--;
      end else if (ready_gap != 0) begin
        out_ready = 1'b0;
        ready_gap--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        ready_gap = $urandom_range(0, 3);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: st=%0d item=%0d max=%0d cnt=%0d", out_data.status,
                   out_data.item_value, out_data.largest_value, out_data.entry_count);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.item_value !== want.item_value ||
            out_data.largest_value !== want.largest_value ||
            out_data.entry_count !== want.entry_count) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch (st item max cnt): exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                     want.status, want.item_value, want.largest_value, want.entry_count,
                     out_data.status, out_data.item_value, out_data.largest_value,
                     out_data.entry_count);
        end
      end
    end
  end

  task automatic test_empty_stack();
    send_op(REQ_POP);
    send_op(REQ_PEEK);
    send_op(REQ_SPARE);
  endtask

  task automatic test_extremes();
    send_item(mk_req(REQ_PUSH, 32'h8000_0000));
    send_op(REQ_PEEK);
    send_item(mk_req(REQ_PUSH, 32'hffff_ff9c));
    send_item(mk_req(REQ_PUSH, 32'hffff_fffb));
    send_op(REQ_SPARE);
    send_item(mk_req(REQ_PUSH, 32'h7fff_ffff));
    send_item(mk_req(REQ_PUSH, 32'h0000_0000));
    send_item(mk_req(REQ_PUSH, 32'hffff_ffff));
    send_op(REQ_PEEK);
    // drain through the maxima back to the negative-only part, then past empty
    repeat (7) send_op(REQ_POP);
    send_op(REQ_PEEK);
  endtask

  task automatic test_full_stack();
    repeat (STACK_DEPTH) send_op(REQ_PUSH);
    send_item(mk_req(REQ_PUSH, 32'h7fff_ffff));
    send_op(REQ_PEEK);
    repeat (STACK_DEPTH) send_op(REQ_POP);
    send_op(REQ_POP);
  endtask

  task automatic test_backpressure();
    hold_req = 300;
    repeat (100) send_op(($urandom_range(0, 3) == 0) ? REQ_PEEK : REQ_PUSH);
    repeat (40) send_op(REQ_POP);
  endtask

  // Phases that lean toward push or pop walk the stack between empty and full.
  task automatic test_random_walk(int unsigned n_items, bit with_idle);
    int unsigned sent;
    int unsigned phase_len;
    int unsigned push_pct;
    int unsigned pick;
    logic [1:0]  op;
    sent = 0;
    while (sent < n_items) begin
      phase_len = $urandom_range(40, 120);
      if (phase_len > n_items - sent) phase_len = n_items - sent;
      case ($urandom_range(0, 2))
        0: push_pct = 75;
        1: push_pct = 25;
        default: push_pct = 50;
      endcase
      idle_en = with_idle && ($urandom_range(0, 3) != 0);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < push_pct) op = REQ_PUSH;
        else if (pick < push_pct + (100 - push_pct) * 3 / 4) op = REQ_POP;
        else if ($urandom_range(0, 3) == 0) op = REQ_SPARE;
        else op = REQ_PEEK;
        send_op(op);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    idle_en = 1'b1;
    hold_req = 0;
    depth_cnt = 0;
    mismatch_cnt = 0;
    cycle_cnt = 0;
    repeat (4) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    test_empty_stack();
    test_extremes();
    test_full_stack();
    test_backpressure();
    test_random_walk(1200, 1'b1);
    test_random_walk(200, 1'b0);

    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
